FILE: hw/rtl/servo_rp_pkg.sv
// Package for the servo record and playback core: word types, command and
// register codes, field widths and the sample-to-width mapping function.
// No dependencies.
package servo_rp_pkg;

   // Field widths.
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned CHAN_W     = 2;
   localparam int unsigned SAMPLE_W   = 12;
   localparam int unsigned NUM_CHAN   = 3;
   localparam int unsigned WIDTH_W    = 11;
   localparam int unsigned PERIOD_W   = 15;
   localparam int unsigned INTERVAL_W = 17;
   localparam int unsigned ENTRY_W    = NUM_CHAN * WIDTH_W;
   localparam int unsigned CSR_IDX_W  = 2;

   // Defaults.
   localparam int unsigned DEFAULT_STORE_DEPTH = 128;
   localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = PERIOD_W'(20000);
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(100000);
   localparam logic [WIDTH_W-1:0]    WIDTH_CENTRE   = WIDTH_W'(1500);
   localparam logic [WIDTH_W-1:0]    WIDTH_LOW_BASE = WIDTH_W'(1000);
   localparam logic [WIDTH_W-1:0]    WIDTH_MAX      = WIDTH_W'(2000);

   // Sample mapping: the dead band runs from LO_LIMIT up to HI_START - 1.
   localparam logic [SAMPLE_W-1:0] LO_LIMIT = SAMPLE_W'(1948);
   localparam logic [SAMPLE_W-1:0] HI_START = SAMPLE_W'(2147);
   localparam longint unsigned LO_DIV    = 1947;
   localparam longint unsigned HI_DIV    = 1948;
   localparam longint unsigned SPAN      = 500;
   localparam int unsigned     MAP_SHIFT = 24;
   localparam int unsigned     MUL_W     = 23;
   localparam int unsigned     QUOT_W    = 9;

   // Rounded-up reciprocals of 1947/500 and 1948/500, scaled by 2^MAP_SHIFT.
   // With a 12-bit operand the truncated product equals the exact quotient.
   localparam logic [MUL_W-1:0] MUL_LO =
      MUL_W'((SPAN * (64'd1 << MAP_SHIFT) + LO_DIV - 1) / LO_DIV);
   localparam logic [MUL_W-1:0] MUL_HI =
      MUL_W'((SPAN * (64'd1 << MAP_SHIFT) + HI_DIV - 1) / HI_DIV);

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_MODE   = 2'd2,
      CMD_SPARE  = 2'd3
   } cmd_type;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PWM_PERIOD      = 2'd0,
      CSR_SAMPLE_INTERVAL = 2'd1,
      CSR_SPARE_A         = 2'd2,
      CSR_SPARE_B         = 2'd3
   } csr_idx_type;

   // Input word.
   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [NUM_CHAN-1:0] servo_pins;
      logic [WIDTH_W-1:0]  width_a;
      logic [WIDTH_W-1:0]  width_b;
      logic [WIDTH_W-1:0]  width_c;
      logic                in_playback;
   } rsp_type;

   // Potentiometer value to pulse width, using one shared multiplier.
   function automatic logic [WIDTH_W-1:0] map_sample(input logic [SAMPLE_W-1:0] v);
      logic [SAMPLE_W-1:0]       x;
      logic [MUL_W-1:0]          k;
      logic [WIDTH_W-1:0]        base;
      logic [SAMPLE_W+MUL_W-1:0] prod;
      logic [QUOT_W-1:0]         quot;
      if (v < LO_LIMIT) begin
         x    = v;
         k    = MUL_LO;
         base = WIDTH_LOW_BASE;
      end else if (v < HI_START) begin
         x    = '0;
         k    = '0;
         base = WIDTH_CENTRE;
      end else begin
         x    = v - HI_START;
         k    = MUL_HI;
         base = WIDTH_CENTRE;
      end
      prod = {{MUL_W{1'b0}}, x} * {{SAMPLE_W{1'b0}}, k};
      quot = prod[MAP_SHIFT +: QUOT_W];
      return base + WIDTH_W'(quot);
   endfunction

endpackage

FILE: hw/rtl/servo_record_playback_core.sv
// Three-channel servo pulse generator with a record and replay ring.
// Depends on servo_rp_pkg.

// The core, unless stalled, accepts one word per cycle and returns one result
// word for each, showing the pin levels, the three pulse widths and the mode after
// that word. A tick word advances the frame counter and, every
// sample_interval ticks, stores the widths into the ring (follow mode) or
// loads the next ring entry (playback mode); a sample word sets one channel's
// width in follow mode; a mode word toggles playback. All work for a word is
// done in the cycle it is accepted, with a single multiplier for the sample
// mapping; the ring entry to be replayed next is read in advance through the
// ring memory's own read port, so replay never holds up a word. Results
// leave through an output register backed by a skid register, so req_stall
// rises only when both are full. The ring needs no clearing pass: entries not
// yet recorded are tracked by the record pointer and a wrap flag and read as
// zero. Configuration writes are always ready.
module servo_record_playback_core
   import servo_rp_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input words
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // Result words
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // Register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [INTERVAL_W-1:0] csr_data
);

   localparam int unsigned PTR_W = $clog2(STORE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STORE_DEPTH - 1);

   // Registers
   logic [PERIOD_W-1:0]   period_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [PERIOD_W-1:0]   frame_ff, frame_in;
   logic [INTERVAL_W-1:0] rec_cnt_ff, rec_cnt_in;
   logic [INTERVAL_W-1:0] play_cnt_ff, play_cnt_in;
   logic [WIDTH_W-1:0]    widths_ff [NUM_CHAN];
   logic [WIDTH_W-1:0]    widths_in [NUM_CHAN];
   logic [NUM_CHAN-1:0]   pins_ff, pins_in;
   logic                  mode_ff, mode_in;
   logic [PTR_W-1:0]      rec_ptr_ff, rec_ptr_in;
   logic [PTR_W-1:0]      play_ptr_ff, play_ptr_in;
   logic                  wrapped_ff, wrapped_in;

   // Ring memory and its look-ahead read
   logic [ENTRY_W-1:0]    store_mem [STORE_DEPTH];
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic [ENTRY_W-1:0]    byp_data_ff;
   logic                  byp_ff, byp_in;
   logic                  entry_valid_ff, entry_valid_in;
   logic [ENTRY_W-1:0]    entry_rd;
   logic                  wr_en;
   logic [ENTRY_W-1:0]    wr_data;

   // Output register and skid register
   rsp_type               rsp_ff, skid_ff, res_in;
   logic                  rsp_valid_ff, skid_valid_ff;

   // Step helpers
   logic                  in_acc;
   logic [PERIOD_W-1:0]   frame_inc;
   logic [INTERVAL_W-1:0] rec_inc, play_inc;
   logic [WIDTH_W-1:0]    mapped;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign in_acc    = req_valid && !skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration registers; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= PERIOD_RESET;
         interval_ff <= INTERVAL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_PWM_PERIOD:      period_ff   <= csr_data[PERIOD_W-1:0];
            CSR_SAMPLE_INTERVAL: interval_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sample mapping and counter increments.
   assign mapped    = map_sample(req_data.sample);
   assign frame_inc = frame_ff + PERIOD_W'(1);
   assign rec_inc   = rec_cnt_ff + INTERVAL_W'(1);
   assign play_inc  = play_cnt_ff + INTERVAL_W'(1);

   // Entry to replay next; entries never recorded read as zero.
   assign entry_rd = entry_valid_ff ? (byp_ff ? byp_data_ff : rd_data_ff) : '0;
   assign wr_data  = {widths_ff[2], widths_ff[1], widths_ff[0]};

   // Next state for the accepted word.
   always_comb begin
      frame_in    = frame_ff;
      rec_cnt_in  = rec_cnt_ff;
      play_cnt_in = play_cnt_ff;
      widths_in   = widths_ff;
      pins_in     = pins_ff;
      mode_in     = mode_ff;
      rec_ptr_in  = rec_ptr_ff;
      play_ptr_in = play_ptr_ff;
      wrapped_in  = wrapped_ff;
      wr_en       = 1'b0;
      if (in_acc) begin
         case (cmd_type'(req_data.cmd))
            CMD_TICK: begin
               // Frame counter: all pins rise on the wrap, then matching pins fall.
               frame_in = frame_inc;
               if (frame_inc >= period_ff) begin
                  frame_in = '0;
                  pins_in  = '1;
               end
               for (int i = 0; i < NUM_CHAN; i++) begin
                  if (frame_in == PERIOD_W'(widths_ff[i])) begin
                     pins_in[i] = 1'b0;
                  end
               end
               // Record step in follow mode.
               rec_cnt_in = rec_inc;
               if (rec_inc >= interval_ff) begin
                  rec_cnt_in = '0;
                  if (!mode_ff) begin
                     wr_en = 1'b1;
                     if (rec_ptr_ff == PTR_LAST) begin
                        rec_ptr_in = '0;
                        wrapped_in = 1'b1;
                     end else begin
                        rec_ptr_in = rec_ptr_ff + PTR_W'(1);
                     end
                  end
               end
               // Replay step in playback mode.
               if (mode_ff) begin
                  play_cnt_in = play_inc;
                  if (play_inc >= interval_ff) begin
                     play_cnt_in  = '0;
                     widths_in[0] = entry_rd[0*WIDTH_W +: WIDTH_W];
                     widths_in[1] = entry_rd[1*WIDTH_W +: WIDTH_W];
                     widths_in[2] = entry_rd[2*WIDTH_W +: WIDTH_W];
                     play_ptr_in  = (play_ptr_ff == PTR_LAST) ? '0
                                                              : play_ptr_ff + PTR_W'(1);
                  end
               end
            end
            CMD_SAMPLE: begin
               if (!mode_ff && (req_data.channel < CHAN_W'(NUM_CHAN))) begin
                  widths_in[req_data.channel] = mapped;
               end
            end
            CMD_MODE: begin
               mode_in     = !mode_ff;
               play_cnt_in = '0;
            end
            default: ;
         endcase
      end
   end

   // Look-ahead controls for the ring read at the next play pointer.
   assign byp_in         = wr_en && (rec_ptr_ff == play_ptr_in);
   assign entry_valid_in = wrapped_in || (play_ptr_in < rec_ptr_in);

   assign res_in = '{servo_pins:  pins_in,
                     width_a:     widths_in[0],
                     width_b:     widths_in[1],
                     width_c:     widths_in[2],
                     in_playback: mode_in};

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff       <= '0;
         rec_cnt_ff     <= '0;
         play_cnt_ff    <= '0;
         widths_ff      <= '{default: WIDTH_CENTRE};
         pins_ff        <= '0;
         mode_ff        <= 1'b0;
         rec_ptr_ff     <= '0;
         play_ptr_ff    <= '0;
         wrapped_ff     <= 1'b0;
         entry_valid_ff <= 1'b0;
         byp_ff         <= 1'b0;
      end else begin
         frame_ff       <= frame_in;
         rec_cnt_ff     <= rec_cnt_in;
         play_cnt_ff    <= play_cnt_in;
         widths_ff      <= widths_in;
         pins_ff        <= pins_in;
         mode_ff        <= mode_in;
         rec_ptr_ff     <= rec_ptr_in;
         play_ptr_ff    <= play_ptr_in;
         wrapped_ff     <= wrapped_in;
         entry_valid_ff <= entry_valid_in;
         byp_ff         <= byp_in;
      end
   end

   // Ring memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[rec_ptr_ff] <= wr_data;
      end
      rd_data_ff  <= store_mem[play_ptr_in];
      byp_data_ff <= wr_data;
   end

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= in_acc;
         end
      end else if (in_acc) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
         end else if (in_acc) begin
            rsp_ff <= res_in;
         end
      end else if (in_acc) begin
         skid_ff <= res_in;
      end
   end

`ifndef SYNTH
   // The skid register only fills behind a held output word.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // Nothing is recorded during playback.
   a_no_record_in_playback: assert property (@(posedge clock) disable iff (reset)
      mode_ff |-> !wr_en)
      else $error("ring written in playback mode");

   // Both ring pointers stay inside the ring.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rec_ptr_ff} < (PTR_W+1)'(STORE_DEPTH)) &&
      ({1'b0, play_ptr_ff} < (PTR_W+1)'(STORE_DEPTH)))
      else $error("ring pointer out of range");

   // Widths, whether mapped or replayed, never exceed the top of the range.
   a_width_range: assert property (@(posedge clock) disable iff (reset)
      (widths_ff[0] <= WIDTH_MAX) && (widths_ff[1] <= WIDTH_MAX) &&
      (widths_ff[2] <= WIDTH_MAX))
      else $error("pulse width out of range");
`endif

endmodule

FILE: dv/servo_record_playback_core_checker.sv
`timescale 1ns / 1ps
// Checker for the servo record and playback core: watches the word, result
// and register channels, predicts every result word and compares it.
// Depends on servo_rp_pkg.
module servo_record_playback_core_checker
   import servo_rp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [INTERVAL_W-1:0] csr_data,
   output int                    mismatch_count,
   output int                    words_pending,
   output int                    words_checked,
   output int                    ring_writes,
   output int                    ring_reads
);

   localparam int unsigned RING_DEPTH = DEFAULT_STORE_DEPTH;
   localparam int          REPORT_LIMIT = 10;

   // Predicted register and core state.
   logic [PERIOD_W-1:0]   period_reg;
   logic [INTERVAL_W-1:0] interval_reg;
   logic [PERIOD_W-1:0]   frame_ctr;
   logic [INTERVAL_W-1:0] record_ctr;
   logic [INTERVAL_W-1:0] play_ctr;
   logic [WIDTH_W-1:0]    width_now [NUM_CHAN];
   logic [NUM_CHAN-1:0]   pin_state;
   logic                  playback;
   logic [ENTRY_W-1:0]    ring [RING_DEPTH];
   int unsigned           rec_ptr;
   int unsigned           play_ptr;

   // Result words still owed by the core, oldest first.
   rsp_type expected_words [$];
   int      fail_tally;
   int      checked_tally;
   int      write_tally;
   int      read_tally;

   // Potentiometer value to pulse width, exact integer division.
   function automatic logic [WIDTH_W-1:0] pulse_width_for(input logic [SAMPLE_W-1:0] v);
      int unsigned s;
      s = v;
      if (s < 1948)
         return WIDTH_W'(1000 + (s * 500) / 1947);
      else if (s < 2147)
         return WIDTH_W'(1500);
      else
         return WIDTH_W'(1500 + ((s - 2147) * 500) / 1948);
   endfunction

   task automatic reset_model();
      period_reg   = PERIOD_RESET;
      interval_reg = INTERVAL_RESET;
      frame_ctr    = '0;
      record_ctr   = '0;
      play_ctr     = '0;
      foreach (width_now[i]) width_now[i] = WIDTH_CENTRE;
      pin_state    = '0;
      playback     = 1'b0;
      foreach (ring[i]) ring[i] = '0;
      rec_ptr      = 0;
      play_ptr     = 0;
      expected_words.delete();
      fail_tally    = 0;
      checked_tally = 0;
      write_tally   = 0;
      read_tally    = 0;
   endtask

   // One microsecond tick: frame counter and pins, then record or replay.
   task automatic frame_tick();
      logic [ENTRY_W-1:0] entry;
      frame_ctr = frame_ctr + 1'b1;
      if (frame_ctr >= period_reg) begin
         frame_ctr = '0;
         pin_state = '1;
      end
      // Falling edges are applied after the wrap, so they win.
      for (int i = 0; i < NUM_CHAN; i++) begin
         if ({{(PERIOD_W-WIDTH_W){1'b0}}, width_now[i]} == frame_ctr)
            pin_state[i] = 1'b0;
      end

      record_ctr = record_ctr + 1'b1;
      if (record_ctr >= interval_reg) begin
         record_ctr = '0;
         if (!playback) begin
            ring[rec_ptr] = {width_now[2], width_now[1], width_now[0]};
            rec_ptr = (rec_ptr + 1) % RING_DEPTH;
            write_tally++;
         end
      end

      if (playback) begin
         play_ctr = play_ctr + 1'b1;
         if (play_ctr >= interval_reg) begin
            play_ctr     = '0;
            entry        = ring[play_ptr];
            width_now[0] = entry[WIDTH_W-1:0];
            width_now[1] = entry[2*WIDTH_W-1:WIDTH_W];
            width_now[2] = entry[3*WIDTH_W-1:2*WIDTH_W];
            play_ptr     = (play_ptr + 1) % RING_DEPTH;
            read_tally++;
         end
      end
   endtask

   // Apply one accepted input word and queue the result it must produce.
   task automatic apply_word(input req_type w);
      rsp_type want;
      case (cmd_type'(w.cmd))
         CMD_TICK: begin
            frame_tick();
         end
         CMD_SAMPLE: begin
            if (!playback && w.channel < NUM_CHAN)
               width_now[w.channel] = pulse_width_for(w.sample);
         end
         CMD_MODE: begin
            playback = !playback;
            play_ctr = '0;
         end
         default: ;
      endcase
      want.servo_pins  = pin_state;
      want.width_a     = width_now[0];
      want.width_b     = width_now[1];
      want.width_c     = width_now[2];
      want.in_playback = playback;
      expected_words.push_back(want);
   endtask

   task automatic check_word(input rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         fail_tally++;
         if (fail_tally <= REPORT_LIMIT)
            $display("%0t: result word with none expected: pins %b widths %0d %0d %0d mode %0b",
                     $realtime, got.servo_pins, got.width_a, got.width_b, got.width_c,
                     got.in_playback);
      end else begin
         want = expected_words.pop_front();
         checked_tally++;
         if (got !== want) begin
            fail_tally++;
            if (fail_tally <= REPORT_LIMIT) begin
               $display("%0t: result %0d differs", $realtime, checked_tally);
               $display("   expected pins %b widths %0d %0d %0d mode %0b",
                        want.servo_pins, want.width_a, want.width_b, want.width_c,
                        want.in_playback);
               $display("   actual   pins %b widths %0d %0d %0d mode %0b",
                        got.servo_pins, got.width_a, got.width_b, got.width_c,
                        got.in_playback);
            end
         end
      end
   endtask

   // Register writes, then the result leaving, then the word arriving.
   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_PWM_PERIOD:      period_reg = csr_data[PERIOD_W-1:0];
               CSR_SAMPLE_INTERVAL: interval_reg = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall)
            check_word(rsp_data);
         if (req_valid && !req_stall)
            apply_word(req_data);
      end
      mismatch_count <= fail_tally;
      words_pending  <= expected_words.size();
      words_checked  <= checked_tally;
      ring_writes    <= write_tally;
      ring_reads     <= read_tally;
   end

endmodule

FILE: dv/servo_record_playback_core_tb.sv
`timescale 1ns / 1ps
// Top of the servo record and playback testbench: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on servo_rp_pkg, the core and
// servo_record_playback_core_checker.
module servo_record_playback_core_tb;
   import servo_rp_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 12;
   localparam int IDLE_PERCENT   = 22;
   localparam int HOLD_CYCLES    = 60;
   localparam int SETTLE_CYCLES  = 10;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int NUM_PHASES     = 7;
   localparam int HOLD_PHASE     = 4;
   localparam int CALM_PHASE     = 5;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_PWM_PERIOD;
   logic [INTERVAL_W-1:0] csr_data = '0;

   int mismatch_count;
   int words_pending;
   int words_checked;
   int ring_writes;
   int ring_reads;
   int phase_no = -1;
   int words_sent = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   servo_record_playback_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   servo_record_playback_core_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending),
      .words_checked  (words_checked),
      .ring_writes    (ring_writes),
      .ring_reads     (ring_reads)
   );

   function automatic req_type make_word(input cmd_type c, input logic [CHAN_W-1:0] ch,
                                         input logic [SAMPLE_W-1:0] s);
      req_type w;
      w.cmd     = c;
      w.channel = ch;
      w.sample  = s;
      return w;
   endfunction

   // Random word. The sweep is mostly ticks, with a few samples near the
   // bottom of the range.
   function automatic req_type random_word(input bit sweep);
      logic [SAMPLE_W-1:0] marks [6] = '{12'd0, 12'd1947, 12'd1948, 12'd2146, 12'd2147,
                                         12'd4095};
      req_type w;
      int      roll;
      roll      = $urandom_range(99);
      w.cmd     = CMD_TICK;
      w.channel = CHAN_W'($urandom_range(NUM_CHAN - 1));
      w.sample  = SAMPLE_W'($urandom_range(4095));
      if (sweep) begin
         if (roll >= 90 && roll < 99) begin
            w.cmd    = CMD_SAMPLE;
            w.sample = SAMPLE_W'($urandom_range(60));
         end else if (roll == 99) begin
            w.cmd = CMD_MODE;
         end
      end else if (roll >= 55 && roll < 88) begin
         w.cmd = CMD_SAMPLE;
         if ($urandom_range(3) == 0)
            w.sample = marks[$urandom_range(5)];
      end else if (roll >= 88 && roll < 94) begin
         w.cmd = CMD_MODE;
      end else if (roll >= 94 && roll < 97) begin
         w.cmd     = CMD_SPARE;
         w.channel = CHAN_W'($urandom_range(3));
      end else if (roll >= 97) begin
         // Sample for the channel that does not exist.
         w.cmd     = CMD_SAMPLE;
         w.channel = 2'd3;
      end
      return w;
   endfunction

   // Offer one word, with random gaps first when asked, until it is taken.
   task automatic send_word(input req_type w, input bit gappy);
      while (gappy && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Write both timing registers back to back, optionally also a spare index.
   task automatic program_timing(input logic [INTERVAL_W-1:0] period,
                                 input logic [INTERVAL_W-1:0] interval, input bit poke_spare);
      csr_idx_type           idx [3];
      logic [INTERVAL_W-1:0] val [3];
      int                    n;
      idx[0] = CSR_PWM_PERIOD;
      val[0] = period;
      idx[1] = CSR_SAMPLE_INTERVAL;
      val[1] = interval;
      idx[2] = CSR_SPARE_A;
      val[2] = '1;
      n = poke_spare ? 3 : 2;
      for (int i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Wait until every result word owed has been taken.
   task automatic drain();
      do @(posedge clock); while (words_pending != 0);
   endtask

   // Receiver: random stalls, one long hold-off, and a calm phase.
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
         end else if (!hold_done && phase_no == HOLD_PHASE) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0)
            rsp_stall <= 1'b1;
         else if (reset || phase_no == CALM_PHASE)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Stimulus and verdict.
   initial begin
      req_type               directed [$];
      logic [INTERVAL_W-1:0] period;
      logic [INTERVAL_W-1:0] interval;
      int                    count;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: mapping edges, ignored words, record then replay
      // past the recorded entries into never-written ones.
      program_timing(17'd5, 17'd2, 1'b1);
      phase_no <= 0;
      directed.push_back(make_word(CMD_SAMPLE, 2'd0, 12'd0));
      directed.push_back(make_word(CMD_SAMPLE, 2'd1, 12'd1947));
      directed.push_back(make_word(CMD_SAMPLE, 2'd2, 12'd1948));
      directed.push_back(make_word(CMD_SAMPLE, 2'd0, 12'd2146));
      directed.push_back(make_word(CMD_SAMPLE, 2'd1, 12'd2147));
      directed.push_back(make_word(CMD_SAMPLE, 2'd2, 12'd4095));
      directed.push_back(make_word(CMD_SAMPLE, 2'd3, 12'd1234));
      directed.push_back(make_word(CMD_SPARE, 2'd3, 12'd4095));
      repeat (6) directed.push_back(make_word(CMD_TICK, 2'd0, 12'd0));
      directed.push_back(make_word(CMD_MODE, 2'd0, 12'd0));
      directed.push_back(make_word(CMD_SAMPLE, 2'd1, 12'd0));
      repeat (8) directed.push_back(make_word(CMD_TICK, 2'd0, 12'd0));
      directed.push_back(make_word(CMD_MODE, 2'd0, 12'd0));
      foreach (directed[i]) send_word(directed[i], 1'b1);
      req_valid <= 1'b0;
      drain();

      // Random phases, each under its own timing setting.
      for (int p = 1; p < NUM_PHASES; p++) begin
         case (p)
            1:       begin period = 17'd32767; interval = 17'd131071; count = 70;  end
            2:       begin period = 17'd1;     interval = 17'd1;      count = 60;  end
            3:       begin period = 17'd0;     interval = 17'd0;      count = 50;  end
            4:       begin period = 17'd9;     interval = 17'd3;      count = 150; end
            5:       begin period = 17'd200;   interval = 17'd1;      count = 320; end
            default: begin period = 17'd40;    interval = 17'd7;      count = 75;  end
         endcase
         program_timing(period, interval, 1'b0);
         phase_no <= p;
         repeat (count) send_word(random_word(p == CALM_PHASE), p != CALM_PHASE);
         req_valid <= 1'b0;
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d words under seven timing settings, including both extremes and zero.",
               words_sent);
      $display("Checked %0d results; %0d ring entries recorded and %0d replayed.",
               words_checked, ring_writes, ring_reads);
      if (mismatch_count == 0 && words_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
